/* rtl/binary_gcd_core_macros.svh */
// Assertion helpers shared by the binary GCD RTL.
// Both expect clk and rst in scope.
`ifndef BINARY_GCD_CORE_MACROS_SVH
`define BINARY_GCD_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define BGCD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BGCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/bgcd_pkg.sv */
// ----------------------------------------------------------------------------
// bgcd_pkg
// Widths, stage count and the per-stage data type of the binary GCD pipeline.
// ----------------------------------------------------------------------------
package bgcd_pkg;

  // Operand width of the arithmetic (legal range 4..63).
  localparam int WIDTH = 32;

  // Port fields are fixed at 32 bits.
  localparam int FIELD_W = 32;

  // Operands wider than the port fields gain nothing.
  localparam int EFF_W = (WIDTH < FIELD_W) ? WIDTH : FIELD_W;

  // Magnitude of the most negative operand is 2^(EFF_W-1): still fits in EFF_W bits.
  localparam int MAG_W = EFF_W;

  // Common power-of-two count, at most EFF_W-1.
  localparam int K_W = $clog2(EFF_W);

  // Every step cuts bitlen(x)+bitlen(y) by at least one, so 2*EFF_W steps
  // always drive x to zero.
  localparam int NUM_STEPS = 2 * EFF_W;

  typedef struct packed {
    logic [MAG_W-1:0] x;
    logic [MAG_W-1:0] y;
    logic [K_W-1:0]   k;
  } bgcd_lane_t;

endpackage

/* rtl/binary_gcd_core.sv */
// ----------------------------------------------------------------------------
// binary_gcd_core
// Binary (Stein) GCD of two signed operands, fully pipelined.
// Pipeline, from input beat to result:
//   one entry stage, 2*EFF_W subtract-and-halve stages, one output stage.
// Throughput: one beat per cycle; the whole chain holds while a result waits.
// Reset: synchronous, clears all valid bits; stage data is not reset.
// ----------------------------------------------------------------------------
module binary_gcd_core import bgcd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               operand_valid,
  output logic               operand_ready,
  input  logic [FIELD_W-1:0] operand_a,
  input  logic [FIELD_W-1:0] operand_b,
  output logic               divisor_valid,
  input  logic               divisor_ready,
  output logic [FIELD_W-1:0] divisor
);

  logic                 en;
  logic [NUM_STEPS:0]   stage_valid;
  bgcd_lane_t           stage_lane [NUM_STEPS+1];

  // advance unless the output register holds an untaken beat
  assign en            = ~divisor_valid | divisor_ready;
  assign operand_ready = en;

  bgcd_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (operand_valid),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .out_valid (stage_valid[0]),
    .lane_out  (stage_lane[0])
  );

  for (genvar i = 0; i < NUM_STEPS; i++) begin : g_step
    bgcd_step u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (stage_valid[i]),
      .lane_in   (stage_lane[i]),
      .out_valid (stage_valid[i+1]),
      .lane_out  (stage_lane[i+1])
    );
  end

  bgcd_final u_final (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .in_valid      (stage_valid[NUM_STEPS]),
    .lane_in       (stage_lane[NUM_STEPS]),
    .divisor_valid (divisor_valid),
    .divisor       (divisor)
  );

endmodule

/* rtl/bgcd_prep.sv */
// ----------------------------------------------------------------------------
// bgcd_prep
// Entry stage: magnitudes of both operands, zero operand steered into x.
// ----------------------------------------------------------------------------
module bgcd_prep import bgcd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [FIELD_W-1:0] operand_a,
  input  logic [FIELD_W-1:0] operand_b,
  output logic               out_valid,
  output bgcd_lane_t         lane_out
);

  logic [MAG_W-1:0] raw_a;
  logic [MAG_W-1:0] raw_b;
  logic [MAG_W-1:0] mag_a;
  logic [MAG_W-1:0] mag_b;
  bgcd_lane_t       lane_next;

  assign raw_a = operand_a[MAG_W-1:0];
  assign raw_b = operand_b[MAG_W-1:0];

  always_comb begin
    mag_a = raw_a[MAG_W-1] ? (~raw_a + MAG_W'(1)) : raw_a;
    mag_b = raw_b[MAG_W-1] ? (~raw_b + MAG_W'(1)) : raw_b;
    lane_next.k = '0;
    // x == 0 marks a finished lane; gcd(a, 0) = a, so park a in y.
    if (mag_b == '0) begin
      lane_next.x = '0;
      lane_next.y = mag_a;
    end else begin
      lane_next.x = mag_a;
      lane_next.y = mag_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      lane_out <= lane_next;
    end
  end

endmodule

/* rtl/bgcd_step.sv */
// ----------------------------------------------------------------------------
// bgcd_step
// One Stein iteration: halve the even operand(s), or subtract the smaller odd
// operand from the larger and halve the even difference.
// ----------------------------------------------------------------------------
`include "binary_gcd_core_macros.svh"

module bgcd_step import bgcd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_valid,
  input  bgcd_lane_t lane_in,
  output logic       out_valid,
  output bgcd_lane_t lane_out
);

  logic [MAG_W:0]   diff_xy;
  logic [MAG_W-1:0] diff_yx;
  logic             x_ge_y;
  bgcd_lane_t       lane_next;

  assign diff_xy = {1'b0, lane_in.x} - {1'b0, lane_in.y};
  assign diff_yx = lane_in.y - lane_in.x;
  assign x_ge_y  = ~diff_xy[MAG_W];

  always_comb begin
    lane_next = lane_in;
    if (lane_in.x == '0) begin
      // finished: pass through
      lane_next = lane_in;
    end else if (!lane_in.x[0] && !lane_in.y[0]) begin
      lane_next.x = lane_in.x >> 1;
      lane_next.y = lane_in.y >> 1;
      lane_next.k = lane_in.k + K_W'(1);
    end else if (!lane_in.x[0]) begin
      lane_next.x = lane_in.x >> 1;
    end else if (!lane_in.y[0]) begin
      lane_next.y = lane_in.y >> 1;
    end else if (x_ge_y) begin
      lane_next.x = diff_xy[MAG_W-1:0] >> 1;
    end else begin
      lane_next.y = diff_yx >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      lane_out <= lane_next;
    end
  end

  `BGCD_ASSERT_NEXT(a_done_holds, en && in_valid && (lane_in.x == '0), (lane_out.x == '0) && (lane_out.y == $past(lane_in.y)), "finished lane changed in step")
  `BGCD_ASSERT_NOW(a_y_live, out_valid && (lane_out.x != '0), lane_out.y != '0, "y reached zero while x is live")

endmodule

/* rtl/bgcd_final.sv */
// ----------------------------------------------------------------------------
// bgcd_final
// Output register: restores the common power of two, y << k.
// ----------------------------------------------------------------------------
`include "binary_gcd_core_macros.svh"

module bgcd_final import bgcd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  bgcd_lane_t         lane_in,
  output logic               divisor_valid,
  output logic [FIELD_W-1:0] divisor
);

  logic [MAG_W-1:0] scaled;

  // gcd <= 2^(MAG_W-1), so the shift never overflows MAG_W bits
  assign scaled = lane_in.y << lane_in.k;

  always_ff @(posedge clk) begin
    if (rst) begin
      divisor_valid <= 1'b0;
    end else if (en) begin
      divisor_valid <= in_valid;
    end
    if (en) begin
      divisor <= FIELD_W'(scaled);
    end
  end

  `BGCD_ASSERT_NOW(a_converged, in_valid, lane_in.x == '0, "step chain too short: x not zero")
  `BGCD_ASSERT_NOW(a_k_bound, in_valid && (lane_in.y != '0), lane_in.y[0] || (lane_in.k == '0), "even survivor with nonzero shift count")

endmodule

/* test/tb_binary_gcd_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_gcd_core
// Self-checking bench for the pipelined binary GCD core. Operand pairs are
// pushed through the input channel with random gaps. Every accepted pair is
// scored against a behavioral Stein GCD, and divisor beats are checked in order.
// The output side stalls at random. Twice it holds off long enough to back the
// whole pipeline up into the input channel.
// ----------------------------------------------------------------------------
module tb_binary_gcd_core;
  import bgcd_pkg::*;

  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 2 * EFF_W + 12;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 1030;

  localparam logic [FIELD_W-1:0] MOST_NEG = {1'b1, {(FIELD_W-1){1'b0}}};
  localparam logic [FIELD_W-1:0] MOST_POS = {1'b0, {(FIELD_W-1){1'b1}}};
  localparam logic [FIELD_W-1:0] MINUS_ONE = {FIELD_W{1'b1}};

  typedef struct {
    logic [FIELD_W-1:0] a;
    logic [FIELD_W-1:0] b;
    bit                 tight;  // no idling around this beat on either side
  } operand_pair_t;

  typedef struct {
    logic [FIELD_W-1:0] a;
    logic [FIELD_W-1:0] b;
    logic [FIELD_W-1:0] gcd;
  } gcd_expect_t;

  logic               clk           = 1'b0;
  logic               rst           = 1'b1;
  logic               operand_valid = 1'b0;
  logic               operand_ready;
  logic [FIELD_W-1:0] operand_a     = '0;
  logic [FIELD_W-1:0] operand_b     = '0;
  logic               divisor_valid;
  logic               divisor_ready = 1'b0;
  logic [FIELD_W-1:0] divisor;

  operand_pair_t pending_pairs[$];
  gcd_expect_t   gcd_expected[$];
  operand_pair_t next_pair;
  gcd_expect_t   oldest_gcd;

  logic op_fire  = 1'b0;
  logic res_fire = 1'b0;
  bit   tight_now = 1'b0;
  int   op_gap = 0;
  int   rx_gap = 0;
  int   hold_left = 0;
  int   holds_done = 0;
  int   beats_in = 0;
  int   results_seen = 0;
  int   zero_operands = 0;
  int   stalled_cycles = 0;
  int   err_count = 0;
  int   idle_cycles = 0;

  binary_gcd_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .operand_valid (operand_valid),
    .operand_ready (operand_ready),
    .operand_a     (operand_a),
    .operand_b     (operand_b),
    .divisor_valid (divisor_valid),
    .divisor_ready (divisor_ready),
    .divisor       (divisor)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Magnitude of the low EFF_W bits taken as two's complement; the most
  // negative value keeps its full magnitude.
  function automatic logic [63:0] operand_magnitude(logic [FIELD_W-1:0] raw);
    logic [63:0] mask;
    logic [63:0] sign_bit;
    logic [63:0] v;
    mask     = (64'd1 << EFF_W) - 64'd1;
    sign_bit = 64'd1 << (EFF_W - 1);
    v        = {32'd0, raw} & mask;
    if ((v & sign_bit) != 0) begin
      return (~v + 64'd1) & mask;
    end
    return v;
  endfunction

  function automatic logic [FIELD_W-1:0] stein_gcd(logic [FIELD_W-1:0] a_raw,
                                                  logic [FIELD_W-1:0] b_raw);
    logic [63:0] x;
    logic [63:0] y;
    int          k;
    x = operand_magnitude(a_raw);
    y = operand_magnitude(b_raw);
    k = 0;
    if (x == 0) return y[FIELD_W-1:0];
    if (y == 0) return x[FIELD_W-1:0];
    while (((x | y) & 64'd1) == 0) begin
      x = x >> 1;
      y = y >> 1;
      k++;
    end
    while (x != 0) begin
      while (x[0] == 1'b0) x = x >> 1;
      while (y[0] == 1'b0) y = y >> 1;
      if (x >= y) x = x - y;
      else        y = y - x;
    end
    y = y << k;
    return y[FIELD_W-1:0];
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int pick_gap(bit tight);
    int unsigned r;
    if (tight) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic operand_pair_t random_pair(bit tight);
    operand_pair_t      p;
    logic [FIELD_W-1:0] g;
    logic [FIELD_W-1:0] extremes [5];
    logic [FIELD_W-1:0] swap;
    int unsigned        sh;
    extremes[0] = '0;
    extremes[1] = MOST_NEG;
    extremes[2] = MOST_POS;
    extremes[3] = MINUS_ONE;
    extremes[4] = 1;
    p.tight = tight;
    sh = $urandom_range(0, 20);
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        p.a = $urandom;
        p.b = $urandom;
      end
      // shared factor with a shared power of two: big divisors, long shifts
      3, 4, 5: begin
        g   = $urandom_range(1, 16'hFFFF);
        p.a = (g * $urandom_range(0, 16'h7FFF)) << sh;
        p.b = (g * $urandom_range(0, 16'h7FFF)) << sh;
      end
      6: begin
        p.a = $urandom_range(0, 64);
        p.b = $urandom_range(0, 64);
      end
      7: begin
        p.a = 1 << $urandom_range(0, 31);
        p.b = (($urandom << 1) | 1) << $urandom_range(0, 31);
      end
      8: begin
        p.a = extremes[$urandom_range(0, 4)];
        p.b = $urandom >> $urandom_range(0, 31);
      end
      default: begin
        p.a = $urandom >> $urandom_range(0, 28);
        p.b = p.a * $urandom_range(1, 7);
      end
    endcase
    if ($urandom_range(0, 1)) p.a = -p.a;
    if ($urandom_range(0, 1)) p.b = -p.b;
    if ($urandom_range(0, 1)) begin
      swap = p.a;
      p.a  = p.b;
      p.b  = swap;
    end
    return p;
  endfunction

  function automatic void queue_pair(logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b);
    operand_pair_t p;
    p.a     = a;
    p.b     = b;
    p.tight = 1'b0;
    pending_pairs.push_back(p);
  endfunction

  // Driver: a new beat goes out only once the previous one was taken.
  always @(negedge clk) begin
    if (rst) begin
      operand_valid <= 1'b0;
    end else if (!operand_valid || op_fire) begin
      if (op_gap > 0) begin
        operand_valid <= 1'b0;
        op_gap <= op_gap - 1;
      end else if (pending_pairs.size() != 0) begin
        next_pair = pending_pairs.pop_front();
        operand_a     <= next_pair.a;
        operand_b     <= next_pair.b;
        operand_valid <= 1'b1;
        tight_now     <= next_pair.tight;
        op_gap        <= pick_gap(next_pair.tight);
      end else begin
        operand_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus two long hold-offs that back up the pipe.
  always @(negedge clk) begin
    if (rst) begin
      divisor_ready <= 1'b0;
    end else if (hold_left > 0) begin
      divisor_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done < 2 && results_seen >= (holds_done == 0 ? 150 : 650)) begin
      divisor_ready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end else if (rx_gap > 0) begin
      divisor_ready <= 1'b0;
      rx_gap <= rx_gap - 1;
    end else begin
      divisor_ready <= 1'b1;
      if (res_fire) rx_gap <= pick_gap(tight_now);
    end
  end

  // Monitor and scoreboard.
  always @(posedge clk) begin
    if (rst) begin
      op_fire  <= 1'b0;
      res_fire <= 1'b0;
    end else begin
      op_fire  <= operand_valid && operand_ready;
      res_fire <= divisor_valid && divisor_ready;
      if (operand_valid && !operand_ready) stalled_cycles++;
      if (operand_valid && operand_ready) begin
        oldest_gcd.a   = operand_a;
        oldest_gcd.b   = operand_b;
        oldest_gcd.gcd = stein_gcd(operand_a, operand_b);
        gcd_expected.push_back(oldest_gcd);
        beats_in++;
        if (operand_a == 0 || operand_b == 0) zero_operands++;
      end
      if (divisor_valid && divisor_ready) begin
        results_seen++;
        if (gcd_expected.size() == 0) begin
          err_count++;
          $display("%0t: divisor beat %0h with nothing expected", $time, divisor);
        end else begin
          oldest_gcd = gcd_expected.pop_front();
          if (divisor !== oldest_gcd.gcd) begin
            err_count++;
            $display("%0t: gcd(%0d, %0d) expected %0d, got %0d", $time,
                     $signed(oldest_gcd.a), $signed(oldest_gcd.b), oldest_gcd.gcd,
                     divisor);
          end
        end
      end
    end
  end

  // Watchdog on cycles with no beat on either channel.
  always @(posedge clk) begin
    if (!rst) begin
      if ((operand_valid && operand_ready) || (divisor_valid && divisor_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d results outstanding", $time,
                 IDLE_LIMIT, gcd_expected.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int i;
    // zero operands and both zero
    queue_pair(0, 0);
    queue_pair(0, 5);
    queue_pair(-7, 0);
    // most negative operand keeps its full magnitude
    queue_pair(MOST_NEG, 0);
    queue_pair(0, MOST_NEG);
    queue_pair(MOST_NEG, MOST_NEG);
    queue_pair(MOST_NEG, MINUS_ONE);
    queue_pair(MOST_NEG, 1 << 20);
    queue_pair(MOST_POS, MOST_POS);
    queue_pair(MOST_POS, MOST_NEG);
    queue_pair(MOST_POS, 1);
    queue_pair(MINUS_ONE, MINUS_ONE);
    queue_pair(1, 0);
    queue_pair(48, -18);
    queue_pair(-1024, 768);
    queue_pair(1 << 30, 1 << 20);
    queue_pair(-12, -18);
    queue_pair(2147483629, 2147483587);
    queue_pair(32'h7FFF_FFFE, 32'h4000_0000);
    queue_pair(15, 40);
    queue_pair(3 << 29, 9 << 27);
    queue_pair(32'hAAAA_AAAA, 32'h5555_5555);
    // runs of 40 unthrottled beats now and then
    for (i = 0; i < RANDOM_ITEMS; i++)
      pending_pairs.push_back(random_pair(((i / 40) % 6) == 3));

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    while (pending_pairs.size() != 0 || operand_valid) @(posedge clk);
    while (gcd_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d operand beats (%0d with a zero operand) and %0d divisor beats.",
             beats_in, zero_operands, results_seen);
    $display("Input channel stalled %0d cycles under output hold-off.", stalled_cycles);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/bgcd_pkg.sv
rtl/bgcd_prep.sv
rtl/bgcd_step.sv
rtl/bgcd_final.sv
rtl/binary_gcd_core.sv
test/tb_binary_gcd_core.sv
